>>> design/ibm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibm_pkg
// Shared types and constants for the incremental block mean.
// ----------------------------------------------------------------------------
package ibm_pkg;

   localparam int COUNT_BITS   = 16;
   localparam int DIVISOR_BITS = COUNT_BITS + 1;

   typedef logic [COUNT_BITS-1:0]   count_type;
   typedef logic [DIVISOR_BITS-1:0] divisor_type;

   localparam count_type   BLOCK_SIZE_RESET = count_type'(16);
   localparam divisor_type COUNT_FULL       = divisor_type'(1) << COUNT_BITS;

endpackage

>>> design/ibm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibm_divider
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit in SAMPLE_BITS bits, so only that many steps are run.
// ----------------------------------------------------------------------------
module ibm_divider
   import ibm_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [COUNT_BITS+SAMPLE_BITS-1:0]   dividend,
   input  divisor_type                         divisor,
   output logic                                done,
   output logic [SAMPLE_BITS-1:0]              quotient
);

   localparam int W          = COUNT_BITS + SAMPLE_BITS;
   localparam int STEP_BITS  = $clog2(SAMPLE_BITS);

   logic                   running_ff, running_in;
   logic                   done_ff, done_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [W-1:0]           rem_ff, rem_in;
   logic [W-1:0]           dsr_ff, dsr_in;
   logic [SAMPLE_BITS-1:0] quo_ff, quo_in;
   logic [W:0]             diff;

   assign diff = {1'b0, rem_ff} - {1'b0, dsr_ff};

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      dsr_in     = dsr_ff;
      quo_in     = quo_ff;
      if (start && !running_ff) begin
         running_in = 1'b1;
         step_in    = STEP_BITS'(SAMPLE_BITS - 1);
         rem_in     = dividend;
         dsr_in     = {divisor, {(SAMPLE_BITS-1){1'b0}}};
         quo_in     = '0;
      end else if (running_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
         end
         quo_in = {quo_ff[SAMPLE_BITS-2:0], ~diff[W]};
         dsr_in = dsr_ff >> 1;
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == '0) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         step_ff    <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/incremental_block_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_block_mean
// Running truncated mean of converter samples, emitted once per block.
// ----------------------------------------------------------------------------
// Each accepted sample updates mean = (count*mean + sample) / (count+1),
// truncated at every step. When the count reaches csr block size (zero
// means 65536, and a block always closes at 65536) the mean is sent on the
// rsp channel and the mean and count clear. A new sample is accepted only
// once the previous one is done: after the accept cycle come the multiply,
// the divide launch, the restoring divider (one quotient bit per cycle), a
// step to see the divider finish, and the commit. req_stall is high for all
// but the accept cycle; a closing sample also waits in the commit step
// while a previous result is unread. Writing csr changes only the block
// size; mean and count are kept.
// ----------------------------------------------------------------------------
module incremental_block_mean
   import ibm_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_block_average,
   input  logic                   csr_wr_en,
   input  count_type              csr_wr_data
);

   localparam int W = COUNT_BITS + SAMPLE_BITS;

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIN} state_type;

   state_type              state_ff;
   count_type              block_size_ff;
   count_type              count_ff;
   logic [SAMPLE_BITS-1:0] mean_ff;
   logic [SAMPLE_BITS-1:0] last_average_ff;
   logic                   rsp_valid_ff;
   logic                   div_start_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [W-1:0]           weighted_ff, weighted_in;

   divisor_type            next_count;
   divisor_type            limit;
   logic                   close;
   logic                   result_load;
   logic                   req_accept;
   logic                   div_done;
   logic [SAMPLE_BITS-1:0] div_quotient;

   assign req_accept  = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign next_count  = {1'b0, count_ff} + divisor_type'(1);
   assign limit       = (block_size_ff == '0) ? COUNT_FULL : {1'b0, block_size_ff};
   assign close       = (next_count == limit) || next_count[COUNT_BITS];
   assign result_load = (state_ff == ST_FIN) && close && !(rsp_valid_ff && rsp_stall);
   assign weighted_in = W'(count_ff) * W'(mean_ff) + W'(sample_ff);

   ibm_divider #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (weighted_ff),
      .divisor  (next_count),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         block_size_ff   <= BLOCK_SIZE_RESET;
         count_ff        <= '0;
         mean_ff         <= '0;
         last_average_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         div_start_ff    <= 1'b0;
      end else begin
         div_start_ff <= (state_ff == ST_MUL);
         if (csr_wr_en) begin
            block_size_ff <= csr_wr_data;
         end
         if (result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (!close) begin
                  mean_ff  <= div_quotient;
                  count_ff <= next_count[COUNT_BITS-1:0];
                  state_ff <= ST_IDLE;
               end else if (result_load) begin
                  last_average_ff <= div_quotient;
                  mean_ff         <= '0;
                  count_ff        <= '0;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_sample;
      end
      if (state_ff == ST_MUL) begin
         weighted_ff <= weighted_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_average = last_average_ff;

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN && close))
      else $error("result raised outside a closing commit");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_mean_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> ((div_quotient <= mean_ff) || (div_quotient <= sample_ff)))
      else $error("new mean exceeds both old mean and sample");

endmodule

>>> sim/incremental_block_mean_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_block_mean_tb
// Self-checking bench for the per-block truncated running mean.
// ----------------------------------------------------------------------------
// A directed table runs the reset block size, the single-sample and largest
// block sizes, zero as a full 16-bit block, and register writes in the middle
// of a block. Random phases then vary the block size, the samples and the
// idle gaps on both channels. Every accepted sample runs through a
// bench-side model of the mean; each block_average transaction is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
module incremental_block_mean_tb
   import ibm_pkg::*;
();

   localparam int SAMPLE_BITS  = 10;
   localparam int HALF_PERIOD  = 4;
   localparam int DRAIN_CYCLES = SAMPLE_BITS + 10;
   localparam int HANG_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 600;
   localparam int TAIL_ITEMS   = 20;
   localparam int PLAN_ROWS    = 18;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int unsigned  value;
      int           reps;
      bit           pinned;
      sample_type   average;
   } plan_row_type;

   // Pinned averages are the ones that follow directly from the update rule.
   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_SAMPLE, 1023, 15, 1'b0, 10'd0},
      '{ROW_SAMPLE,    0,  1, 1'b1, 10'd959},
      '{ROW_WRITE,     1,  1, 1'b0, 10'd0},
      '{ROW_SAMPLE,    0,  1, 1'b1, 10'd0},
      '{ROW_SAMPLE, 1023,  1, 1'b1, 10'd1023},
      '{ROW_SAMPLE,  682,  1, 1'b1, 10'd682},
      '{ROW_SAMPLE,  341,  1, 1'b1, 10'd341},
      '{ROW_WRITE,     2,  1, 1'b0, 10'd0},
      '{ROW_SAMPLE, 1023,  1, 1'b0, 10'd0},
      '{ROW_SAMPLE, 1022,  1, 1'b1, 10'd1022},
      '{ROW_WRITE, 65535,  1, 1'b0, 10'd0},
      '{ROW_SAMPLE, 1023,  3, 1'b0, 10'd0},
      '{ROW_WRITE,     4,  1, 1'b0, 10'd0},
      '{ROW_SAMPLE,    0,  1, 1'b1, 10'd767},
      '{ROW_WRITE,     0,  1, 1'b0, 10'd0},
      '{ROW_SAMPLE,    5,  2, 1'b0, 10'd0},
      '{ROW_WRITE,     3,  1, 1'b0, 10'd0},
      '{ROW_SAMPLE,    8,  1, 1'b1, 10'd6}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   sample_type req_sample = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b1;
   sample_type rsp_block_average;
   logic       csr_wr_en = 1'b0;
   count_type  csr_wr_data = '0;

   // bench-side mean state
   sample_type  mean_value = '0;
   int unsigned mean_count = 0;
   count_type   block_size_q = BLOCK_SIZE_RESET;
   sample_type  pending_averages [$];

   bit         pin_pending = 1'b0;
   sample_type pin_average = '0;
   int         req_run = 0;
   int         rsp_run = 0;
   int         errors = 0;
   int         hang_cycles = 0;

   incremental_block_mean #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_block_average(rsp_block_average),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Folds one sample into the mean; returns 1 when the block closes.
   function automatic bit fold_sample(input sample_type s, output sample_type avg);
      longint unsigned weighted;
      int unsigned     next_count;
      int unsigned     limit;
      weighted   = 64'(mean_count) * 64'(mean_value) + 64'(s);
      next_count = mean_count + 1;
      limit      = (block_size_q == '0) ? int'(COUNT_FULL) : int'(block_size_q);
      mean_value = sample_type'(weighted / next_count);
      avg        = mean_value;
      if (next_count == limit || next_count >= COUNT_FULL) begin
         mean_value = '0;
         mean_count = 0;
         return 1'b1;
      end
      mean_count = next_count;
      return 1'b0;
   endfunction

   function automatic int draw_gap(ref int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         run_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic sample_type draw_sample();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Size mostly lies above the running count, so most blocks close soon.
   function automatic count_type pick_block_size();
      int unsigned lo;
      lo = mean_count + 1;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return count_type'($urandom_range(lo, lo + 60));
         default: return count_type'($urandom_range(lo, lo + 6));
      endcase
   endfunction

   // Starts at the falling edge after the previous transaction, returns at
   // the rising edge that accepts this one.
   task automatic push_sample(input sample_type s, input int gap, input bit pinned,
                              input sample_type average);
      @(negedge clock);
      pin_pending = pinned;
      pin_average = average;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic pause_until_drained();
      while (pending_averages.size() != 0) @(negedge clock);
   endtask

   // Idle point: nothing pending and the divider given time to finish.
   task automatic settle();
      idle_req();
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_block_size(input count_type size);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   always begin : drain
      int hold;
      @(negedge clock);
      hold = draw_gap(rsp_run);
      if (hold > 0) begin
         rsp_stall <= 1'b1;
         repeat (hold) @(negedge clock);
      end
      rsp_stall <= 1'b0;
      do @(posedge clock); while (!(rsp_valid && !rsp_stall));
   end

   always @(posedge clock) begin : scoreboard
      sample_type predicted;
      sample_type wanted;
      if (!reset) begin
         if (csr_wr_en) block_size_q = csr_wr_data;
         if (req_valid && !req_stall) begin
            if (fold_sample(req_sample, predicted))
               pending_averages.push_back(pin_pending ? pin_average : predicted);
            pin_pending = 1'b0;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_averages.size() == 0) begin
               $display("%0t: unexpected transaction, block_average expected none, got %0d",
                        $time, rsp_block_average);
               errors++;
            end else begin
               wanted = pending_averages.pop_front();
               if (rsp_block_average !== wanted) begin
                  $display("%0t: block_average expected %0d, got %0d",
                           $time, wanted, rsp_block_average);
                  errors++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
            hang_cycles <= 0;
         else
            hang_cycles <= hang_cycles + 1;
      end
   end

   initial begin : watchdog
      while (hang_cycles < HANG_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int          sent;
      int          n;
      count_type   size;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            settle();
            write_block_size(count_type'(plan[i].value));
         end else begin
            for (int r = 0; r < plan[i].reps; r++)
               push_sample(sample_type'(plan[i].value), draw_gap(req_run),
                           plan[i].pinned && r == plan[i].reps - 1, plan[i].average);
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         size = pick_block_size();
         write_block_size(size);
         if (size == '0 || size > 64)
            n = $urandom_range(1, 8);
         else
            n = size * $urandom_range(1, 3) + $urandom_range(0, size - 1);
         if (n > RANDOM_ITEMS - sent)
            n = RANDOM_ITEMS - sent;
         repeat (n) begin
            if ($urandom_range(0, 49) == 0) begin
               idle_req();
               pause_until_drained();
            end
            push_sample(draw_sample(), draw_gap(req_run), 1'b0, '0);
            sent++;
         end
      end

      repeat (TAIL_ITEMS) push_sample(draw_sample(), draw_gap(req_run), 1'b0, '0);

      settle();
      if (errors == 0 && pending_averages.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
